@@ src/scancode_key_state_tracker_macros.svh @@
// Assertion macros used by the checker file of the scancode key state tracker.
`ifndef SCANCODE_KEY_STATE_TRACKER_MACROS_SVH
`define SCANCODE_KEY_STATE_TRACKER_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define SKTR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sktr: next-cycle check failed");

// Consequent must hold in the same cycle as the antecedent.
`define SKTR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sktr: same-cycle check failed");

`endif

@@ src/sktr_pkg.sv @@
// Types, constants and codes of the scancode key state tracker.
package sktr_pkg;

	localparam int KEY_COUNT = 96;
	localparam int KEY_IDX_W = 7;
	localparam logic [KEY_IDX_W:0] KEY_LIMIT = (KEY_IDX_W + 1)'(KEY_COUNT);

	// operation codes
	localparam logic [1:0] OP_SCAN      = 2'd0;
	localparam logic [1:0] OP_QUERY_NRM = 2'd1;
	localparam logic [1:0] OP_QUERY_EXT = 2'd2;
	localparam logic [1:0] OP_CLEAR     = 2'd3;

	// scancode byte codes
	localparam logic [7:0] SC_PREFIX_EXT = 8'hE0;
	localparam logic [7:0] SC_PAUSE1     = 8'hE1;
	localparam logic [7:0] SC_PAUSE2     = 8'hE2;
	localparam int         SC_BREAK_BIT  = 7;

	// prefix state codes
	localparam logic [1:0] MODE_NONE = 2'd0;
	localparam logic [1:0] MODE_EXT  = 2'd1;
	localparam logic [1:0] MODE_DROP = 2'd2;

	// key state codes
	localparam logic [1:0] KS_UP       = 2'd0;
	localparam logic [1:0] KS_DOWN     = 2'd1;
	localparam logic [1:0] KS_PRESSED  = 2'd2;
	localparam logic [1:0] KS_RELEASED = 2'd3;

	typedef struct packed {
		logic                 upd;
		logic                 query;
		logic                 make;
		logic [KEY_IDX_W-1:0] idx;
	} tbl_cmd_t;

	typedef struct packed {
		logic       chg;
		logic [1:0] ks;
	} tbl_rsp_t;

endpackage

@@ src/sktr_decode.sv @@
// Item decoder: scancode prefix tracking and per-table command generation.
module sktr_decode (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           valid,
	input  logic [1:0]                     opcode,
	input  logic [7:0]                     scan_byte,
	input  logic [sktr_pkg::KEY_IDX_W-1:0] key_index,
	output sktr_pkg::tbl_cmd_t             nrm_cmd,
	output sktr_pkg::tbl_cmd_t             ext_cmd,
	output logic                           clr
);

	logic [1:0] mode_q;
	logic [1:0] mode_d;
	logic       make;
	logic [sktr_pkg::KEY_IDX_W-1:0] code;

	assign make = ~scan_byte[sktr_pkg::SC_BREAK_BIT];
	assign code = scan_byte[sktr_pkg::KEY_IDX_W-1:0];

	always_comb begin
		mode_d        = mode_q;
		nrm_cmd       = '0;
		ext_cmd       = '0;
		clr           = 1'b0;
		nrm_cmd.make  = make;
		ext_cmd.make  = make;
		nrm_cmd.idx   = code;
		ext_cmd.idx   = code;
		if (valid) begin
			unique case (opcode)
				sktr_pkg::OP_SCAN: begin
					if (mode_q == sktr_pkg::MODE_EXT) begin
						ext_cmd.upd = 1'b1;
						mode_d      = sktr_pkg::MODE_NONE;
					end else if (mode_q != sktr_pkg::MODE_NONE) begin
						// drop the byte after a pause prefix
						mode_d = sktr_pkg::MODE_NONE;
					end else if (scan_byte == sktr_pkg::SC_PREFIX_EXT) begin
						mode_d = sktr_pkg::MODE_EXT;
					end else if (scan_byte == sktr_pkg::SC_PAUSE1 ||
					             scan_byte == sktr_pkg::SC_PAUSE2) begin
						mode_d = sktr_pkg::MODE_DROP;
					end else begin
						nrm_cmd.upd = 1'b1;
					end
				end
				sktr_pkg::OP_QUERY_NRM: begin
					nrm_cmd.query = 1'b1;
					nrm_cmd.idx   = key_index;
				end
				sktr_pkg::OP_QUERY_EXT: begin
					ext_cmd.query = 1'b1;
					ext_cmd.idx   = key_index;
				end
				sktr_pkg::OP_CLEAR: begin
					clr = 1'b1;
				end
				default: begin
					clr = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= sktr_pkg::MODE_NONE;
		end else begin
			mode_q <= mode_d;
		end
	end

endmodule

@@ src/sktr_table.sv @@
// Key table: down and read bits for one set of keys, one read-modify-write per cycle.
module sktr_table (
	input  logic               clk,
	input  logic               arst_n,
	input  sktr_pkg::tbl_cmd_t cmd,
	output sktr_pkg::tbl_rsp_t rsp
);

	logic [sktr_pkg::KEY_COUNT-1:0] down_q;
	logic [sktr_pkg::KEY_COUNT-1:0] seen_q;
	logic hit;
	logic cur_down;
	logic cur_seen;
	logic rd;

	assign hit      = {1'b0, cmd.idx} < sktr_pkg::KEY_LIMIT;
	assign cur_down = hit ? down_q[cmd.idx] : 1'b0;
	assign cur_seen = hit ? seen_q[cmd.idx] : 1'b0;
	assign rd       = cmd.query && hit;

	always_comb begin
		rsp.chg = cmd.upd && hit && (cur_down != cmd.make);
		rsp.ks  = sktr_pkg::KS_UP;
		if (rd) begin
			if (cur_down) begin
				rsp.ks = cur_seen ? sktr_pkg::KS_DOWN : sktr_pkg::KS_PRESSED;
			end else begin
				rsp.ks = cur_seen ? sktr_pkg::KS_UP : sktr_pkg::KS_RELEASED;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			down_q <= '0;
			seen_q <= '0;
		end else begin
			// a key change marks it unread; a query marks it read
			if (rsp.chg) begin
				down_q[cmd.idx] <= cmd.make;
				seen_q[cmd.idx] <= 1'b0;
			end
			if (rd) begin
				seen_q[cmd.idx] <= 1'b1;
			end
		end
	end

endmodule

@@ src/scancode_key_state_tracker.sv @@
// Top level of the scancode key state tracker.
// Usage:
//   Drive opcode, scan_byte and key_index with start high; an item transfers at
//   every rising edge where start is high and busy is low. busy stays low, so an
//   item may transfer in every cycle.
//   opcode 0 feeds a set-1 scancode byte (E0 routes the next byte to the extended
//   table, E1/E2 drop the next byte), 1 and 2 query a normal or extended key,
//   3 clears the any-pressed flag.
//   Each item gives one result: done is high for exactly one cycle, set through the
//   item register and then the result register, carrying key_state and
//   any_pressed. Throughput is one item per cycle: each key table does its
//   read-modify-write between the two registers.
//   The receiver cannot stall: a result is lost unless taken while done is high.
//   Reset (arst_n low) marks all keys up and unread, clears the prefix and the
//   any-pressed flag, and drops any item in flight.
module scancode_key_state_tracker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [1:0]                     opcode,
	input  logic [7:0]                     scan_byte,
	input  logic [sktr_pkg::KEY_IDX_W-1:0] key_index,
	output logic                           done,
	output logic [1:0]                     key_state,
	output logic                           any_pressed
);

	logic                           valid_s1;
	logic [1:0]                     opcode_s1;
	logic [7:0]                     byte_s1;
	logic [sktr_pkg::KEY_IDX_W-1:0] idx_s1;

	sktr_pkg::tbl_cmd_t nrm_cmd;
	sktr_pkg::tbl_cmd_t ext_cmd;
	sktr_pkg::tbl_rsp_t nrm_rsp;
	sktr_pkg::tbl_rsp_t ext_rsp;
	logic               clr;
	logic               any_q;
	logic               any_d;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			opcode_s1 <= opcode;
			byte_s1   <= scan_byte;
			idx_s1    <= key_index;
		end
	end

	sktr_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid     (valid_s1),
		.opcode    (opcode_s1),
		.scan_byte (byte_s1),
		.key_index (idx_s1),
		.nrm_cmd   (nrm_cmd),
		.ext_cmd   (ext_cmd),
		.clr       (clr)
	);

	sktr_table u_nrm_table (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (nrm_cmd),
		.rsp    (nrm_rsp)
	);

	sktr_table u_ext_table (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (ext_cmd),
		.rsp    (ext_rsp)
	);

	// at most one table sees an update in a cycle
	always_comb begin
		any_d = any_q;
		if (clr) begin
			any_d = 1'b0;
		end else if (nrm_rsp.chg) begin
			any_d = nrm_cmd.make;
		end else if (ext_rsp.chg) begin
			any_d = ext_cmd.make;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_q <= 1'b0;
			done  <= 1'b0;
		end else begin
			any_q <= any_d;
			done  <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			key_state <= nrm_rsp.ks | ext_rsp.ks;
		end
	end

	assign any_pressed = any_q;

endmodule

@@ src/sktr_checker.sv @@
// Port-level checker for the scancode key state tracker, bound to the top level.
`include "scancode_key_state_tracker_macros.svh"

module sktr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] opcode,
	input logic       done,
	input logic [1:0] key_state,
	input logic       any_pressed
);

	logic xfer;
	logic xfer_d1;

	assign xfer = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xfer_d1 <= 1'b0;
		end else begin
			xfer_d1 <= xfer;
		end
	end

	`SKTR_ASSERT_NEXT(a_done_after_xfer, xfer_d1, done)
	`SKTR_ASSERT_NEXT(a_no_spurious_done, !xfer_d1, !done)
	`SKTR_ASSERT_NOW(a_never_busy, 1'b1, !busy)
	`SKTR_ASSERT_NEXT(a_clear_result, xfer_d1 && $past(opcode) == sktr_pkg::OP_CLEAR,
		!any_pressed && key_state == sktr_pkg::KS_UP)
	`SKTR_ASSERT_NEXT(a_scan_state_up, xfer_d1 && $past(opcode) == sktr_pkg::OP_SCAN,
		key_state == sktr_pkg::KS_UP)

endmodule

bind scancode_key_state_tracker sktr_checker u_sktr_checker (.*);

@@ dv/scancode_key_state_tracker_tb.sv @@
// Self-checking testbench of the scancode key state tracker: directed and random items.
`timescale 1ns / 1ps

module scancode_key_state_tracker_tb;

	localparam int ITEM_COUNT     = 1250;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES   = 6;
	localparam int PRINT_LIMIT    = 40;
	localparam int IDX_W          = sktr_pkg::KEY_IDX_W;
	localparam int KEYS           = sktr_pkg::KEY_COUNT;

	typedef struct packed {
		logic [1:0] ks;
		logic       ap;
	} key_result_t;

	class key_table_scoreboard;
		logic              key_down [2][KEYS];
		logic              key_seen [2][KEYS];
		logic [1:0]        prefix;
		logic              any_flag;
		key_result_t       expected_q [$];
		int                errors;

		function new();
			for (int t = 0; t < 2; t++) begin
				for (int k = 0; k < KEYS; k++) begin
					key_down[t][k] = 1'b0;
					key_seen[t][k] = 1'b0;
				end
			end
			prefix   = sktr_pkg::MODE_NONE;
			any_flag = 1'b0;
			errors   = 0;
		endfunction

		function void set_key(int tbl, logic [6:0] code, logic make);
			if (int'(code) >= KEYS)
				return;
			if (key_down[tbl][code] != make) begin
				key_down[tbl][code] = make;
				key_seen[tbl][code] = 1'b0;
				any_flag = make;
			end
		endfunction

		function logic [1:0] read_key(int tbl, logic [6:0] idx);
			logic [1:0] ks;
			if (int'(idx) >= KEYS)
				return sktr_pkg::KS_UP;
			if (key_down[tbl][idx])
				ks = key_seen[tbl][idx] ? sktr_pkg::KS_DOWN : sktr_pkg::KS_PRESSED;
			else
				ks = key_seen[tbl][idx] ? sktr_pkg::KS_UP : sktr_pkg::KS_RELEASED;
			key_seen[tbl][idx] = 1'b1;
			return ks;
		endfunction

		function void take_scan(logic [7:0] sc);
			logic make;
			make = ~sc[sktr_pkg::SC_BREAK_BIT];
			if (prefix == sktr_pkg::MODE_EXT) begin
				set_key(1, sc[6:0], make);
				prefix = sktr_pkg::MODE_NONE;
			end else if (prefix != sktr_pkg::MODE_NONE) begin
				prefix = sktr_pkg::MODE_NONE;
			end else if (sc == sktr_pkg::SC_PREFIX_EXT) begin
				prefix = sktr_pkg::MODE_EXT;
			end else if (sc == sktr_pkg::SC_PAUSE1 || sc == sktr_pkg::SC_PAUSE2) begin
				prefix = sktr_pkg::MODE_DROP;
			end else begin
				set_key(0, sc[6:0], make);
			end
		endfunction

		function void note_item(logic [1:0] op, logic [7:0] sc, logic [IDX_W-1:0] idx);
			key_result_t r;
			r.ks = sktr_pkg::KS_UP;
			case (op)
				sktr_pkg::OP_SCAN:      take_scan(sc);
				sktr_pkg::OP_QUERY_NRM: r.ks = read_key(0, idx);
				sktr_pkg::OP_QUERY_EXT: r.ks = read_key(1, idx);
				default:                any_flag = 1'b0;
			endcase
			r.ap = any_flag;
			expected_q.push_back(r);
		endfunction

		task report(string msg);
			if (errors < PRINT_LIMIT)
				$display("%0t mismatch: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(logic [1:0] ks, logic ap);
			key_result_t exp;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected result key_state %0d any_pressed %0b", ks, ap));
				return;
			end
			exp = expected_q.pop_front();
			if (ks !== exp.ks)
				report($sformatf("key_state %0d, expected %0d", ks, exp.ks));
			if (ap !== exp.ap)
				report($sformatf("any_pressed %0b, expected %0b", ap, exp.ap));
		endtask

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic [1:0]       opcode;
	logic [7:0]       scan_byte;
	logic [IDX_W-1:0] key_index;
	logic             done;
	logic [1:0]       key_state;
	logic             any_pressed;

	key_table_scoreboard sb;
	int                  idle_cycles;
	bit                  no_idle;

	scancode_key_state_tracker i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.opcode      (opcode),
		.scan_byte   (scan_byte),
		.key_index   (key_index),
		.done        (done),
		.key_state   (key_state),
		.any_pressed (any_pressed)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Note each transfer, check each result and watch for a stalled run.
	always @(posedge clk) begin
		if (arst_n && start && !busy) begin
			sb.note_item(opcode, scan_byte, key_index);
			idle_cycles = 0;
		end else if (arst_n && done) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (arst_n && done)
			sb.check_result(key_state, any_pressed);
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// Mostly a handful of keys so that makes, breaks and queries meet often.
	function logic [6:0] pick_code();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 7'($urandom_range(0, 7));
		else if (r < 90)
			return 7'($urandom_range(0, KEYS - 1));
		else
			return 7'($urandom_range(KEYS, 127));
	endfunction

	// Call at a rising edge; returns at the edge that transfers the item.
	task send_item(logic [1:0] op, logic [7:0] sc, logic [IDX_W-1:0] idx);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start     <= 1'b1;
		opcode    <= op;
		scan_byte <= sc;
		key_index <= idx;
		do @(posedge clk); while (busy);
	endtask

	task send_scan(logic [7:0] sc);
		send_item(sktr_pkg::OP_SCAN, sc, IDX_W'($urandom_range(0, 127)));
	endtask

	task send_query(logic [1:0] op, logic [6:0] idx);
		send_item(op, 8'($urandom_range(0, 255)), idx);
	endtask

	task run_random(int count);
		int n;
		int kind;
		n = 0;
		while (n < count) begin
			if ($urandom_range(0, 79) == 0)
				no_idle = ~no_idle;
			kind = $urandom_range(0, 99);
			if (kind < 30) begin
				send_scan({1'($urandom_range(0, 1)), pick_code()});
				n += 1;
			end else if (kind < 45) begin
				send_scan(sktr_pkg::SC_PREFIX_EXT);
				send_scan({1'($urandom_range(0, 1)), pick_code()});
				n += 2;
			end else if (kind < 50) begin
				send_scan($urandom_range(0, 1) ? sktr_pkg::SC_PAUSE1 : sktr_pkg::SC_PAUSE2);
				send_scan(8'($urandom_range(0, 255)));
				n += 2;
			end else if (kind < 65) begin
				send_query(sktr_pkg::OP_QUERY_NRM, pick_code());
				n += 1;
			end else if (kind < 80) begin
				send_query(sktr_pkg::OP_QUERY_EXT, pick_code());
				n += 1;
			end else if (kind < 85) begin
				send_item(sktr_pkg::OP_CLEAR, 8'($urandom_range(0, 255)),
					IDX_W'($urandom_range(0, 127)));
				n += 1;
			end else begin
				send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
					IDX_W'($urandom_range(0, 127)));
				n += 1;
			end
		end
	endtask

	initial begin
		sb          = new();
		idle_cycles = 0;
		no_idle     = 1'b0;
		arst_n      = 1'b0;
		start       = 1'b0;
		opcode      = sktr_pkg::OP_SCAN;
		scan_byte   = 8'h00;
		key_index   = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// unread keys read as released once, then up; out-of-table queries read up
		send_query(sktr_pkg::OP_QUERY_NRM, 7'd0);
		send_query(sktr_pkg::OP_QUERY_NRM, 7'd0);
		send_query(sktr_pkg::OP_QUERY_EXT, 7'd95);
		send_query(sktr_pkg::OP_QUERY_NRM, 7'd96);
		send_query(sktr_pkg::OP_QUERY_EXT, 7'd127);
		// table edges and a make beyond the table
		send_scan(8'h00);
		send_scan(8'h5F);
		send_scan(8'h7F);
		send_query(sktr_pkg::OP_QUERY_NRM, 7'd95);
		send_query(sktr_pkg::OP_QUERY_NRM, 7'd95);
		// extended make and break
		send_scan(sktr_pkg::SC_PREFIX_EXT);
		send_scan(8'h1D);
		send_query(sktr_pkg::OP_QUERY_EXT, 7'd29);
		send_scan(sktr_pkg::SC_PREFIX_EXT);
		send_query(sktr_pkg::OP_QUERY_NRM, 7'd0);
		send_scan(8'h9D);
		send_query(sktr_pkg::OP_QUERY_EXT, 7'd29);
		// prefix bytes after E0 land out of table; bytes after E1 or E2 drop
		send_scan(sktr_pkg::SC_PREFIX_EXT);
		send_scan(sktr_pkg::SC_PREFIX_EXT);
		send_scan(sktr_pkg::SC_PREFIX_EXT);
		send_scan(sktr_pkg::SC_PAUSE1);
		send_scan(sktr_pkg::SC_PAUSE1);
		send_scan(8'h10);
		send_scan(sktr_pkg::SC_PAUSE2);
		send_scan(sktr_pkg::SC_PREFIX_EXT);
		send_query(sktr_pkg::OP_QUERY_NRM, 7'd16);
		send_item(sktr_pkg::OP_CLEAR, 8'hFF, 7'd127);
		send_scan(8'h80);
		send_scan(8'hFF);

		run_random(ITEM_COUNT);
		start <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ scancode_key_state_tracker.f @@
+incdir+src
src/sktr_pkg.sv
src/sktr_decode.sv
src/sktr_table.sv
src/scancode_key_state_tracker.sv
src/sktr_checker.sv
dv/scancode_key_state_tracker_tb.sv
